@@ hdl/balloc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_pkg - shared types and constants of the buddy allocator
// Status codes, controller states, datapath operations and status flags.
// ----------------------------------------------------------------------------
package balloc_pkg;

   // default pool size in units; the order count follows from it
   localparam int POOL_UNITS_DEF = 1024;

   // free-bitmap memory word
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_SPACE  = 2'd1,
      STAT_BAD_SIZE  = 2'd2,
      STAT_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_ROOT,
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SPLIT,
      S_SPLIT_WR,
      S_FREE_CHK,
      S_MERGE,
      S_MERGE_CHK,
      S_SET_WR,
      S_RESP
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ROOT,
      OP_LOAD,
      OP_ALLOC_INIT,
      OP_SCAN_RD,
      OP_SCAN_NEXT,
      OP_TAKE,
      OP_SPLIT_RD,
      OP_SPLIT_WR,
      OP_AORD_WR,
      OP_FREE_RD,
      OP_FREE_BAD,
      OP_FREE_OK,
      OP_MERGE_RD,
      OP_MERGE_WR,
      OP_SET_RD,
      OP_SET_WR
   } dp_op_type;

   typedef struct packed {
      logic clear_done;
      logic is_free;
      logic bad_size;
      logic no_space;
      logic row_hit;
      logic split_more;
      logic free_bad;
      logic can_up;
      logic bud_free;
   } dp_status_type;

endpackage
`default_nettype wire

@@ hdl/balloc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_if - request and response channels of the buddy allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface balloc_req_if #(
   parameter int SIZE_W = 11,
   parameter int OFF_W  = 10
) ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [SIZE_W-1:0] alloc_units;
   logic [OFF_W-1:0]  block_offset;

   modport source (output valid, cmd, alloc_units, block_offset, input ready);
   modport sink   (input valid, cmd, alloc_units, block_offset, output ready);
endinterface

interface balloc_rsp_if #(
   parameter int OFF_W = 10,
   parameter int ORD_W = 4
) ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [OFF_W-1:0] offset_out;
   logic [ORD_W-1:0] order_out;

   modport source (output valid, status, offset_out, order_out, input ready);
   modport sink   (input valid, status, offset_out, order_out, output ready);
endinterface
`default_nettype wire

@@ hdl/balloc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module balloc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ hdl/balloc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_ctrl - sequencer of the buddy allocator
// Walks the clearing pass, the alloc search/split and the free/merge loop,
// issuing at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module balloc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire balloc_pkg::dp_status_type  status,
   output balloc_pkg::dp_op_type           op
);
   import balloc_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (status.clear_done) state_in = S_ROOT;
         S_ROOT:      state_in = S_IDLE;
         S_IDLE:      if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            priority if (status.is_free)                     state_in = S_FREE_CHK;
            else if (status.bad_size || status.no_space)     state_in = S_RESP;
            else                                             state_in = S_SCAN_RD;
         end
         S_SCAN_RD:   state_in = S_SCAN_CHK;
         S_SCAN_CHK:  state_in = status.row_hit ? S_SPLIT : S_SCAN_RD;
         S_SPLIT:     state_in = status.split_more ? S_SPLIT_WR : S_RESP;
         S_SPLIT_WR:  state_in = S_SPLIT;
         S_FREE_CHK:  state_in = status.free_bad ? S_RESP : S_MERGE;
         S_MERGE:     state_in = status.can_up ? S_MERGE_CHK : S_SET_WR;
         S_MERGE_CHK: state_in = status.bud_free ? S_MERGE : S_SET_WR;
         S_SET_WR:    state_in = S_RESP;
         S_RESP:      if (rsp_ready) state_in = S_IDLE;
         default:     state_in = S_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR:     op = OP_CLEAR;
         S_ROOT:      op = OP_ROOT;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_LOAD;
         end
         S_DISPATCH:  op = status.is_free ? OP_FREE_RD : OP_ALLOC_INIT;
         S_SCAN_RD:   op = OP_SCAN_RD;
         S_SCAN_CHK:  op = status.row_hit ? OP_TAKE : OP_SCAN_NEXT;
         S_SPLIT:     op = status.split_more ? OP_SPLIT_RD : OP_AORD_WR;
         S_SPLIT_WR:  op = OP_SPLIT_WR;
         S_FREE_CHK:  op = status.free_bad ? OP_FREE_BAD : OP_FREE_OK;
         S_MERGE:     op = status.can_up ? OP_MERGE_RD : OP_SET_RD;
         S_MERGE_CHK: op = status.bud_free ? OP_MERGE_WR : OP_SET_RD;
         S_SET_WR:    op = OP_SET_WR;
         S_RESP:      rsp_valid = 1'b1;
         default:     op = OP_NONE;
      endcase
   end
endmodule
`default_nettype wire

@@ hdl/balloc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_dp - datapath of the buddy allocator
// Per-order free bitmaps in one RAM (row address {order, row}), the per-offset
// allocated-order RAM, per-order free counters and the response registers.
// ----------------------------------------------------------------------------
module balloc_dp #(
   parameter int POOL_UNITS = balloc_pkg::POOL_UNITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire balloc_pkg::dp_op_type                 op,
   input  wire logic                                  req_cmd,
   input  wire logic [$clog2(POOL_UNITS):0]           req_size,
   input  wire logic [$clog2(POOL_UNITS)-1:0]         req_offset,
   output balloc_pkg::dp_status_type                  status,
   output logic [1:0]                                 rsp_status,
   output logic [$clog2(POOL_UNITS)-1:0]              rsp_offset,
   output logic [$clog2($clog2(POOL_UNITS)+1)-1:0]    rsp_order
);
   import balloc_pkg::*;

   localparam int OFF_W      = $clog2(POOL_UNITS);
   localparam int SIZE_W     = OFF_W + 1;
   localparam int NUM_ORDERS = OFF_W + 1;
   localparam int ORD_W      = $clog2(NUM_ORDERS);
   localparam int AO_W       = $clog2(NUM_ORDERS + 1);
   localparam int ROWS       = (POOL_UNITS >= WORD_BITS) ? POOL_UNITS / WORD_BITS : 1;
   localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W      = BIT_W + ROW_W;
   localparam int FMA_W      = ORD_W + ROW_W;
   localparam int FM_DEPTH   = 2 ** FMA_W;
   localparam int CLR_N      = (FM_DEPTH > POOL_UNITS) ? FM_DEPTH : POOL_UNITS;
   localparam int CLR_W      = $clog2(CLR_N);
   localparam int CNT_W      = OFF_W + 1;

   // registers
   logic              cmd_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [OFF_W-1:0]  off_ff,  off_in;
   logic [ORD_W-1:0]  kreq_ff, kreq_in;
   logic [ORD_W-1:0]  cur_ff,  cur_in;
   logic [ROW_W-1:0]  row_ff,  row_in;
   logic [CLR_W-1:0]  clr_ff,  clr_in;
   logic [CNT_W-1:0]  cnt_ff [NUM_ORDERS];
   logic [CNT_W-1:0]  cnt_in [NUM_ORDERS];
   status_type        rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]  rsp_off_ff,    rsp_off_in;
   logic [ORD_W-1:0]  rsp_ord_ff,    rsp_ord_in;

   // memory ports
   logic                 fm_we;
   logic [FMA_W-1:0]     fm_waddr, fm_raddr;
   logic [WORD_BITS-1:0] fm_wdata, fm_rdata;
   logic                 ao_we;
   logic [OFF_W-1:0]     ao_waddr;
   logic [AO_W-1:0]      ao_wdata, ao_rdata;

   // working signals
   logic [ORD_W-1:0]     kc, jfree;
   logic                 found;
   logic [ORD_W-1:0]     n_ord;
   logic [IDX_W-1:0]     n_base, n_idx, bud_idx, take_idx;
   logic [FMA_W-1:0]     n_addr, scan_addr;
   logic [WORD_BITS-1:0] n_mask, low_mask;
   logic [BIT_W-1:0]     low_b;
   logic [OFF_W-1:0]     take_off;

   balloc_ram #(.WIDTH(WORD_BITS), .DEPTH(FM_DEPTH)) u_free_ram (
      .clock (clock),
      .we    (fm_we),
      .waddr (fm_waddr),
      .wdata (fm_wdata),
      .raddr (fm_raddr),
      .rdata (fm_rdata)
   );

   balloc_ram #(.WIDTH(AO_W), .DEPTH(POOL_UNITS)) u_order_ram (
      .clock (clock),
      .we    (ao_we),
      .waddr (ao_waddr),
      .wdata (ao_wdata),
      .raddr (off_ff),
      .rdata (ao_rdata)
   );

   // round the request up to an order, then pick the smallest order with a free block
   always_comb begin
      kc    = ORD_W'(NUM_ORDERS - 1);
      jfree = '0;
      found = 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
         if ((SIZE_W'(1) << (NUM_ORDERS - 1 - i)) >= size_ff) begin
            kc = ORD_W'(NUM_ORDERS - 1 - i);
         end
      end
      for (int i = 0; i < NUM_ORDERS; i++) begin
         if (ORD_W'(NUM_ORDERS - 1 - i) >= kc && cnt_ff[NUM_ORDERS - 1 - i] != '0) begin
            jfree = ORD_W'(NUM_ORDERS - 1 - i);
            found = 1'b1;
         end
      end
   end

   // lowest free block in the scanned row
   always_comb begin
      low_b = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (fm_rdata[WORD_BITS - 1 - i]) low_b = BIT_W'(WORD_BITS - 1 - i);
      end
      low_mask = WORD_BITS'(1) << low_b;
      take_idx = {row_ff, low_b};
      take_off = OFF_W'(take_idx << cur_ff);
   end

   // tree node touched by the split, merge and set steps
   always_comb begin
      n_ord  = (op == OP_SPLIT_RD) ? cur_ff - ORD_W'(1) : cur_ff;
      n_base = IDX_W'(off_ff >> n_ord);
      unique case (op)
         OP_SPLIT_RD, OP_SPLIT_WR: n_idx = n_base | IDX_W'(1);
         OP_MERGE_RD, OP_MERGE_WR: n_idx = n_base ^ IDX_W'(1);
         default:                  n_idx = n_base;
      endcase
      n_addr    = {n_ord, n_idx[IDX_W-1:BIT_W]};
      n_mask    = WORD_BITS'(1) << n_idx[BIT_W-1:0];
      scan_addr = {cur_ff, row_ff};
      bud_idx   = IDX_W'(off_ff >> cur_ff) ^ IDX_W'(1);
   end

   // memory writes and read address
   always_comb begin
      fm_we    = 1'b0;
      fm_waddr = n_addr;
      fm_wdata = fm_rdata;
      fm_raddr = (op == OP_SCAN_RD) ? scan_addr : n_addr;
      ao_we    = 1'b0;
      ao_waddr = off_ff;
      ao_wdata = '0;
      unique case (op)
         OP_CLEAR: begin
            fm_we    = 1'b1;
            fm_waddr = clr_ff[FMA_W-1:0];
            fm_wdata = '0;
            ao_we    = 1'b1;
            ao_waddr = clr_ff[OFF_W-1:0];
         end
         OP_ROOT: begin
            fm_we    = 1'b1;
            fm_waddr = {ORD_W'(NUM_ORDERS - 1), ROW_W'(0)};
            fm_wdata = WORD_BITS'(1);
         end
         OP_TAKE: begin
            fm_we    = 1'b1;
            fm_waddr = scan_addr;
            fm_wdata = fm_rdata & ~low_mask;
         end
         OP_SPLIT_WR, OP_SET_WR: begin
            fm_we    = 1'b1;
            fm_wdata = fm_rdata | n_mask;
         end
         OP_MERGE_WR: begin
            fm_we    = 1'b1;
            fm_wdata = fm_rdata & ~n_mask;
         end
         OP_AORD_WR: begin
            ao_we    = 1'b1;
            ao_wdata = AO_W'(kreq_ff) + AO_W'(1);
         end
         OP_FREE_OK: begin
            ao_we    = 1'b1;
         end
         default: begin
            fm_we = 1'b0;
         end
      endcase
   end

   // next values of the working and response registers
   always_comb begin
      off_in        = off_ff;
      kreq_in       = kreq_ff;
      cur_in        = cur_ff;
      row_in        = row_ff;
      clr_in        = clr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_ord_in    = rsp_ord_ff;
      for (int i = 0; i < NUM_ORDERS; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      unique case (op)
         OP_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
         end
         OP_ROOT: begin
            cnt_in[NUM_ORDERS - 1] = CNT_W'(1);
         end
         OP_LOAD: begin
            off_in = req_offset;
         end
         OP_ALLOC_INIT: begin
            kreq_in = kc;
            cur_in  = jfree;
            row_in  = '0;
            priority if (size_ff == '0 || size_ff > SIZE_W'(POOL_UNITS)) begin
               rsp_status_in = STAT_BAD_SIZE;
               rsp_off_in    = '0;
               rsp_ord_in    = '0;
            end else if (!found) begin
               rsp_status_in = STAT_NO_SPACE;
               rsp_off_in    = '0;
               rsp_ord_in    = kc;
            end
         end
         OP_SCAN_NEXT: begin
            row_in = row_ff + ROW_W'(1);
         end
         OP_TAKE: begin
            off_in = take_off;
            for (int i = 0; i < NUM_ORDERS; i++) begin
               if (ORD_W'(i) == cur_ff) cnt_in[i] = cnt_ff[i] - CNT_W'(1);
            end
         end
         OP_SPLIT_RD: begin
            cur_in = cur_ff - ORD_W'(1);
         end
         OP_SPLIT_WR, OP_SET_WR: begin
            for (int i = 0; i < NUM_ORDERS; i++) begin
               if (ORD_W'(i) == cur_ff) cnt_in[i] = cnt_ff[i] + CNT_W'(1);
            end
         end
         OP_AORD_WR: begin
            rsp_status_in = STAT_OK;
            rsp_off_in    = off_ff;
            rsp_ord_in    = kreq_ff;
         end
         OP_FREE_BAD: begin
            rsp_status_in = STAT_NOT_ALLOC;
            rsp_off_in    = off_ff;
            rsp_ord_in    = '0;
         end
         OP_FREE_OK: begin
            cur_in        = ORD_W'(ao_rdata - AO_W'(1));
            rsp_status_in = STAT_OK;
            rsp_off_in    = off_ff;
            rsp_ord_in    = ORD_W'(ao_rdata - AO_W'(1));
         end
         OP_MERGE_WR: begin
            off_in = off_ff & ~(OFF_W'(1) << cur_ff);
            cur_in = cur_ff + ORD_W'(1);
            for (int i = 0; i < NUM_ORDERS; i++) begin
               if (ORD_W'(i) == cur_ff) cnt_in[i] = cnt_ff[i] - CNT_W'(1);
            end
         end
         default: begin
            off_in = off_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         clr_ff <= clr_in;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (op == OP_LOAD) begin
         cmd_ff  <= req_cmd;
         size_ff <= req_size;
      end
      off_ff        <= off_in;
      kreq_ff       <= kreq_in;
      cur_ff        <= cur_in;
      row_ff        <= row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_ord_ff    <= rsp_ord_in;
   end

   // flags for the sequencer
   always_comb begin
      status.clear_done = (clr_ff == CLR_W'(CLR_N - 1));
      status.is_free    = cmd_ff;
      status.bad_size   = (size_ff == '0) || (size_ff > SIZE_W'(POOL_UNITS));
      status.no_space   = !found;
      status.row_hit    = |fm_rdata;
      status.split_more = cur_ff > kreq_ff;
      status.free_bad   = (ao_rdata == '0) || (ao_rdata > AO_W'(NUM_ORDERS));
      status.can_up     = cur_ff < ORD_W'(NUM_ORDERS - 1);
      status.bud_free   = fm_rdata[bud_idx[BIT_W-1:0]];
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_offset = rsp_off_ff;
   assign rsp_order  = rsp_ord_ff;
endmodule
`default_nettype wire

@@ hdl/buddy_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_allocator - binary buddy allocator over a power-of-two unit pool
// Allocates power-of-two blocks (lowest address, smallest fitting order)
// and frees them with repeated buddy merging.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  req_bus | in  | cmd (0 alloc, 1 free), alloc_units, block_offset
//  rsp_bus | out | status, offset_out, order_out (one beat per request)
//
//  An alloc scans bitmap rows of the chosen order, then splits down to the
//  requested order; a free merges with free buddies up the orders. Each step
//  is a read-modify-write of one 32-bit row of the free-bitmap RAM. After
//  reset a clearing pass sweeps both RAMs and no request is taken meanwhile.
//  One request at a time; a held response stalls the next request.
// ----------------------------------------------------------------------------
module buddy_allocator #(
   parameter int POOL_UNITS = balloc_pkg::POOL_UNITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   balloc_req_if.sink    req_bus,
   balloc_rsp_if.source  rsp_bus
);
   import balloc_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   balloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .op        (op)
   );

   balloc_dp #(.POOL_UNITS(POOL_UNITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .req_cmd    (req_bus.cmd),
      .req_size   (req_bus.alloc_units),
      .req_offset (req_bus.block_offset),
      .status     (status),
      .rsp_status (rsp_bus.status),
      .rsp_offset (rsp_bus.offset_out),
      .rsp_order  (rsp_bus.order_out)
   );
endmodule
`default_nettype wire

@@ bench/balloc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balloc_checker - response predictor and scoreboard for the buddy allocator
// Watches request and response beats, keeps its own free tree and order table,
// and compares each response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module balloc_checker (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_ready,
   input  wire logic req_cmd,
   input  wire logic [10:0] req_size,
   input  wire logic [9:0] req_offset,
   input  wire logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic [1:0] rsp_status,
   input  wire logic [9:0] rsp_offset,
   input  wire logic [3:0] rsp_order,
   output int fail_count,
   output int pending_count,
   output int alloc_ok_count,
   output int free_ok_count,
   output int reject_count
);
   import balloc_pkg::*;

   localparam int UNITS  = 1024;
   localparam int ORDERS = 11;

   typedef struct packed {
      status_type status;
      logic [9:0] offset;
      logic [3:0] order;
   } balloc_rsp_t;

   bit         tree_free [2*UNITS-1];
   logic [4:0] held_order [UNITS];
   balloc_rsp_t rsp_queue [$];
   bit          cmd_queue [$];

   function automatic int node_index(int ord, int off);
      return (UNITS >> ord) - 1 + (off >> ord);
   endfunction

   // predict one allocate and update the tree
   function automatic balloc_rsp_t predict_alloc(int size);
      balloc_rsp_t r;
      int k;
      k = 0;
      r = '{STAT_BAD_SIZE, 10'd0, 4'd0};
      if (size == 0 || size > UNITS) return r;
      while (k < ORDERS - 1 && (1 << k) < size) k++;
      for (int j = k; j < ORDERS; j++) begin
         for (int i = 0; i < (UNITS >> j); i++) begin
            if (tree_free[node_index(j, i << j)]) begin
               tree_free[node_index(j, i << j)] = 0;
               for (int m = j; m > k; m--)
                  tree_free[node_index(m - 1, (i << j) + (1 << (m - 1)))] = 1;
               held_order[i << j] = 5'(k + 1);
               r = '{STAT_OK, 10'(i << j), 4'(k)};
               return r;
            end
         end
      end
      r = '{STAT_NO_SPACE, 10'd0, 4'(k)};
      return r;
   endfunction

   // predict one free and merge up the orders
   function automatic balloc_rsp_t predict_free(int off);
      balloc_rsp_t r;
      int k, cur, bud;
      if (held_order[off] == 0) begin
         r = '{STAT_NOT_ALLOC, 10'(off), 4'd0};
         return r;
      end
      k = held_order[off] - 1;
      held_order[off] = 0;
      r = '{STAT_OK, 10'(off), 4'(k)};
      cur = off;
      while (k < ORDERS - 1) begin
         bud = cur ^ (1 << k);
         if (!tree_free[node_index(k, bud)]) break;
         tree_free[node_index(k, bud)] = 0;
         cur &= ~(1 << k);
         k++;
      end
      tree_free[node_index(k, cur)] = 1;
      return r;
   endfunction

   always @(posedge clock) begin
      balloc_rsp_t want;
      bit          was_free;
      if (reset) begin
         foreach (tree_free[i]) tree_free[i] = 0;
         foreach (held_order[i]) held_order[i] = 0;
         tree_free[0] = 1;
         rsp_queue.delete();
         cmd_queue.delete();
         fail_count <= 0;
         alloc_ok_count <= 0;
         free_ok_count <= 0;
         reject_count <= 0;
      end else begin
         // take a request beat
         if (req_valid && req_ready) begin
            rsp_queue.push_back(req_cmd ? predict_free(req_offset) : predict_alloc(req_size));
            cmd_queue.push_back(req_cmd);
         end
         // compare a response beat
         if (rsp_valid && rsp_ready) begin
            if (rsp_queue.size() == 0) begin
               if (fail_count < 10) $display("%0t: response with none pending", $time);
               fail_count <= fail_count + 1;
            end else begin
               want = rsp_queue.pop_front();
               was_free = cmd_queue.pop_front();
               if (want.status != rsp_status || want.offset != rsp_offset ||
                   want.order != rsp_order) begin
                  if (fail_count < 10)
                     $display("%0t: exp st=%0d off=%0d ord=%0d got st=%0d off=%0d ord=%0d",
                              $time, want.status, want.offset, want.order,
                              rsp_status, rsp_offset, rsp_order);
                  fail_count <= fail_count + 1;
               end
               // tally by request kind and outcome
               if (want.status != STAT_OK) begin
                  reject_count <= reject_count + 1;
               end else if (was_free) begin
                  free_ok_count <= free_ok_count + 1;
               end else begin
                  alloc_ok_count <= alloc_ok_count + 1;
               end
            end
         end
      end
      pending_count = rsp_queue.size();
   end
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the buddy allocator
// Directed corner requests, then random alloc/free traffic biased toward
// freeing live blocks, with random gaps and response stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   import balloc_pkg::*;

   localparam int NUM_RANDOM = 1230;
   localparam longint CYCLE_LIMIT = 600000;

   logic clock = 0;
   logic reset = 1;
   int   cycle_count = 0;
   int   fail_count, pending_count, alloc_ok_count, free_ok_count, reject_count;
   bit   idle_free_run = 0;

   balloc_req_if req_bus ();
   balloc_rsp_if rsp_bus ();

   buddy_allocator u_dut (.clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus));

   balloc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_bus.valid), .req_ready(req_bus.ready), .req_cmd(req_bus.cmd),
      .req_size(req_bus.alloc_units), .req_offset(req_bus.block_offset),
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready), .rsp_status(rsp_bus.status),
      .rsp_offset(rsp_bus.offset_out), .rsp_order(rsp_bus.order_out),
      .fail_count(fail_count), .pending_count(pending_count),
      .alloc_ok_count(alloc_ok_count), .free_ok_count(free_ok_count),
      .reject_count(reject_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_bus.valid = 0;
      req_bus.cmd = 0;
      req_bus.alloc_units = 0;
      req_bus.block_offset = 0;
   end

   // count cycles, end on timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stall the response side at random, except in the quiet stretch
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 0;
      else rsp_bus.ready <= idle_free_run || ($urandom_range(99) >= 26);
   end

   // send one beat, with a random gap before it; returns at the accepting edge
   task automatic send_beat(logic cmd, logic [10:0] size, logic [9:0] off);
      @(posedge clock);
      while (!idle_free_run && $urandom_range(99) < 26) @(posedge clock);
      req_bus.valid <= 1;
      req_bus.cmd <= cmd;
      req_bus.alloc_units <= size;
      req_bus.block_offset <= off;
      // ready follows the controller state only, so it is settled at the falling edge
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      req_bus.valid <= 0;
   endtask

   // hold until every predicted response has come back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   int size_pick, off_pick;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: bad sizes, full pool, no space, frees good and bad
      send_beat(0, 11'd0, 10'h3FF);
      send_beat(0, 11'd1025, 10'd0);
      send_beat(0, 11'h7FF, 10'd0);
      send_beat(0, 11'd1024, 10'd0);
      send_beat(0, 11'd1, 10'd0);
      send_beat(1, 11'h7FF, 10'd0);
      send_beat(1, 11'd0, 10'd0);
      send_beat(0, 11'd1, 10'd0);
      send_beat(0, 11'd3, 10'd0);
      send_beat(0, 11'd512, 10'd0);
      send_beat(0, 11'd513, 10'd0);
      send_beat(0, 11'd2, 10'd0);
      send_beat(1, 11'd0, 10'd2);
      send_beat(1, 11'd0, 10'd3);
      send_beat(1, 11'd0, 10'd4);
      send_beat(1, 11'd0, 10'd512);
      send_beat(1, 11'd0, 10'd0);
      send_beat(1, 11'd0, 10'd1);
      send_beat(1, 11'd0, 10'h3FF);
      send_beat(0, 11'd1024, 10'd0);

      // hold off until the pipe drains
      wait_drained();
      repeat (40) @(posedge clock);
      send_beat(1, 11'd0, 10'd0);

      // random traffic: mostly small allocs and frees of live-looking offsets
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 300) idle_free_run = 1;
         if (n == 450) idle_free_run = 0;
         if (n == 700) begin
            wait_drained();
            repeat (40) @(posedge clock);
         end
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               size_pick = ($urandom_range(19) == 0) ? $urandom_range(1024, 1)
                                                     : $urandom_range(40, 1);
               if ($urandom_range(49) == 0) size_pick = $urandom_range(2047);
               send_beat(0, 11'(size_pick), 10'($urandom));
            end
            4, 5, 6, 7, 8: begin
               // small power-of-two aligned offsets hit live blocks often
               off_pick = $urandom_range(127) << $urandom_range(3);
               send_beat(1, 11'($urandom), 10'(off_pick));
            end
            default: send_beat(1, 11'($urandom), 10'($urandom));
         endcase
      end

      wait_drained();
      repeat (60) @(posedge clock);
      $display("Covered %0d ok allocs, %0d ok frees and %0d rejected requests",
               alloc_ok_count, free_ok_count, reject_count);
      $display("over directed corners and random alloc/free traffic with stalls.");
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
